// ----- sv/tktcs_pkg.sv -----
// Shared types and constants of the tick timekeeper with compare scheduler.
// No dependencies; imported by the divider, the top level and the testbench.
package tktcs_pkg;

   localparam int CounterW   = 64;
   localparam int DiffW      = 32;
   localparam int TickW      = 31;
   localparam int MsW        = 10;
   localparam int UptimeW    = 32;
   localparam int SecondsW   = 32;
   localparam int ProductW   = TickW + MsW;
   localparam int DividendW  = DiffW;
   localparam int CsrIndexW  = 2;

   localparam int DigitW     = 10;
   localparam int SecDigits  = 5;
   localparam int SecWorkW   = DigitW * SecDigits;
   localparam int SecStepW   = 2 * DigitW;
   localparam int SecRecipW  = 21;
   localparam int SecShift   = 30;
   localparam int SecCountW  = 3;

   localparam logic [TickW-1:0] TicksReset  = TickW'(72000);
   localparam logic [MsW-1:0]   MsReset     = MsW'(1);
   localparam logic [TickW-1:0] GuardReset  = TickW'(7200);
   localparam logic [MsW-1:0]   MsPerSecond = MsW'(1000);
   localparam logic [SecStepW-1:0]  MsPerSecondWide = SecStepW'(1000);
   localparam logic [SecRecipW-1:0] SecRecip        = SecRecipW'(1073742);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_TICKS_PER_PERIOD = 2'd0,
      CSR_MS_PER_PERIOD    = 2'd1,
      CSR_GUARD_TICKS      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_PERIOD,
      ST_MUL,
      ST_ADD,
      ST_DIV_SECOND,
      ST_NEXT_BASE,
      ST_NEXT_FINAL
   } state_type;

endpackage

// ----- sv/tick_timekeeper_compare_scheduler_top.sv -----
// Top level of the tick timekeeper: sequencer, time-keeping state and output register.
// Depends on tktcs_pkg and the divider tktcs_div.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_counter_value
//   rsp      out        rsp_valid/rsp_ready   next_compare, uptime_ms, fraction_ms, unix_seconds
//   csr      in         csr_write_enable      csr_index, csr_write_data
//
// A beat with a negative difference or a zero period skips both divisions and goes from ST_PREP
// straight to ST_NEXT_BASE and ST_NEXT_FINAL. Otherwise the divider counts whole periods, then
// ST_MUL and ST_ADD update the time and ST_DIV_SECOND carries the milliseconds into seconds.
// A new beat is accepted only in ST_IDLE; ST_NEXT_FINAL waits while the output register is held.
// Reset is synchronous and clears the accounted count and all time state to zero.
// A result waits in the output register while the next beat is accepted.
module tick_timekeeper_compare_scheduler_top import tktcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CounterW-1:0]  req_counter_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CounterW-1:0]  rsp_next_compare,
   output logic [UptimeW-1:0]   rsp_uptime_ms,
   output logic [MsW-1:0]       rsp_fraction_ms,
   output logic [SecondsW-1:0]  rsp_unix_seconds,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [TickW-1:0]     csr_write_data
);

   state_type state_ff, state_in;

   logic [TickW-1:0]    ticks_ff;
   logic [MsW-1:0]      ms_ff;
   logic [TickW-1:0]    guard_ff;

   logic [CounterW-1:0] acc_ff, acc_in;
   logic [UptimeW-1:0]  uptime_ff, uptime_in;
   logic [MsW-1:0]      frac_ff, frac_in;
   logic [SecondsW-1:0] seconds_ff, seconds_in;

   logic [CounterW-1:0] sample_ff, sample_in;
   logic [DiffW-1:0]    dif_ff, dif_in;
   logic [DiffW-1:0]    rem_ff, rem_in;
   logic [TickW-1:0]    periods_ff, periods_in;
   logic [ProductW-1:0] prod_ff, prod_in;
   logic [DiffW-1:0]    moved_ff, moved_in;
   logic [CounterW-1:0] base_ff, base_in;
   logic                skip_ff, skip_in;

   logic [SecWorkW-1:0]  sec_work_ff, sec_work_in;
   logic [MsW-1:0]       sec_rem_ff, sec_rem_in;
   logic [SecondsW-1:0]  sec_quo_ff, sec_quo_in;
   logic [SecCountW-1:0] sec_count_ff, sec_count_in;
   logic [SecStepW-1:0]  sec_num;
   logic [SecStepW+SecRecipW-1:0] sec_prod;
   logic [DigitW-1:0]    sec_digit;
   logic [SecStepW-1:0]  sec_back;
   logic [MsW-1:0]       sec_rem_next;
   logic [SecondsW-1:0]  sec_quo_next;
   logic                 sec_last;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CounterW-1:0] out_next_ff;
   logic [UptimeW-1:0]  out_uptime_ff;
   logic [MsW-1:0]      out_frac_ff;
   logic [SecondsW-1:0] out_seconds_ff;

   logic                 div_start;
   logic                 load_out;
   logic                 div_done;
   logic [DividendW-1:0] div_dividend;
   logic [TickW-1:0]     div_divisor;
   logic [DividendW-1:0] div_quotient;
   logic [TickW-1:0]     div_remainder;

   logic [MsW-1:0]       ms_eff;
   logic                 counts_periods;
   logic signed [DiffW:0] rem_wide;
   logic signed [DiffW:0] threshold;
   logic [DiffW-1:0]     step;

   assign ms_eff         = (ms_ff > MsPerSecond) ? MsPerSecond : ms_ff;
   assign counts_periods = !dif_ff[DiffW-1] && (ticks_ff != '0);
   assign rem_wide       = $signed({rem_ff[DiffW-1], rem_ff});
   assign threshold      = $signed({2'b00, ticks_ff}) - $signed({2'b00, guard_ff});
   assign step           = skip_ff ? {ticks_ff, 1'b0} : {1'b0, ticks_ff};

   // One base-1024 digit of the division by 1000 per cycle, by reciprocal multiplication.
   assign sec_num      = {sec_rem_ff, sec_work_ff[SecWorkW-1 -: DigitW]};
   assign sec_prod     = {{SecRecipW{1'b0}}, sec_num} * {{SecStepW{1'b0}}, SecRecip};
   assign sec_digit    = sec_prod[SecShift +: DigitW];
   assign sec_back     = sec_num - {{DigitW{1'b0}}, sec_digit} * MsPerSecondWide;
   assign sec_rem_next = sec_back[MsW-1:0];
   assign sec_quo_next = {sec_quo_ff[SecondsW-DigitW-1:0], sec_digit};
   assign sec_last     = (sec_count_ff == SecCountW'(SecDigits - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = counts_periods ? ST_DIV_PERIOD : ST_NEXT_BASE;
         end
         ST_DIV_PERIOD: begin
            if (div_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_DIV_SECOND;
         end
         ST_DIV_SECOND: begin
            if (sec_last) state_in = ST_NEXT_BASE;
         end
         ST_NEXT_BASE: begin
            state_in = ST_NEXT_FINAL;
         end
         ST_NEXT_FINAL: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_PREP: div_start = counts_periods;
         ST_NEXT_FINAL: load_out = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign div_dividend = dif_ff;
   assign div_divisor  = ticks_ff;

   tktcs_div #(
      .DividendWidth(DividendW),
      .DivisorWidth (TickW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   always_comb begin
      sample_in    = sample_ff;
      dif_in       = dif_ff;
      rem_in       = rem_ff;
      periods_in   = periods_ff;
      prod_in      = prod_ff;
      moved_in     = moved_ff;
      base_in      = base_ff;
      skip_in      = skip_ff;
      acc_in       = acc_ff;
      uptime_in    = uptime_ff;
      frac_in      = frac_ff;
      seconds_in   = seconds_ff;
      sec_work_in  = sec_work_ff;
      sec_rem_in   = sec_rem_ff;
      sec_quo_in   = sec_quo_ff;
      sec_count_in = sec_count_ff;
      case (state_ff)
         ST_IDLE: begin
            sample_in = req_counter_value;
            dif_in    = req_counter_value[DiffW-1:0] - acc_ff[DiffW-1:0];
         end
         ST_PREP: begin
            rem_in = dif_ff;
         end
         ST_DIV_PERIOD: begin
            periods_in = div_quotient[TickW-1:0];
            rem_in     = {1'b0, div_remainder};
         end
         ST_MUL: begin
            prod_in  = {{MsW{1'b0}}, periods_ff} * {{TickW{1'b0}}, ms_eff};
            moved_in = dif_ff - rem_ff;
         end
         ST_ADD: begin
            acc_in       = acc_ff + {{(CounterW-DiffW){1'b0}}, moved_ff};
            uptime_in    = uptime_ff + prod_ff[UptimeW-1:0];
            sec_work_in  = {{(SecWorkW-ProductW){1'b0}}, prod_ff}
                           + {{(SecWorkW-MsW){1'b0}}, frac_ff};
            sec_rem_in   = '0;
            sec_quo_in   = '0;
            sec_count_in = '0;
         end
         ST_DIV_SECOND: begin
            sec_work_in  = {sec_work_ff[SecWorkW-DigitW-1:0], {DigitW{1'b0}}};
            sec_rem_in   = sec_rem_next;
            sec_quo_in   = sec_quo_next;
            sec_count_in = sec_count_ff + SecCountW'(1);
            if (sec_last) begin
               seconds_in = seconds_ff + sec_quo_next;
               frac_in    = sec_rem_next;
            end
         end
         ST_NEXT_BASE: begin
            base_in = sample_ff - {{(CounterW-DiffW){rem_ff[DiffW-1]}}, rem_ff};
            skip_in = (rem_wide >= threshold);
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= TicksReset;
         ms_ff        <= MsReset;
         guard_ff     <= GuardReset;
         acc_ff       <= '0;
         uptime_ff    <= '0;
         frac_ff      <= '0;
         seconds_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         uptime_ff    <= uptime_in;
         frac_ff      <= frac_in;
         seconds_ff   <= seconds_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TICKS_PER_PERIOD: ticks_ff <= csr_write_data;
               CSR_MS_PER_PERIOD:    ms_ff    <= csr_write_data[MsW-1:0];
               CSR_GUARD_TICKS:      guard_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      dif_ff       <= dif_in;
      rem_ff       <= rem_in;
      periods_ff   <= periods_in;
      prod_ff      <= prod_in;
      moved_ff     <= moved_in;
      base_ff      <= base_in;
      skip_ff      <= skip_in;
      sec_work_ff  <= sec_work_in;
      sec_rem_ff   <= sec_rem_in;
      sec_quo_ff   <= sec_quo_in;
      sec_count_ff <= sec_count_in;
      if (load_out) begin
         out_next_ff    <= base_ff + {{(CounterW-DiffW){1'b0}}, step};
         out_uptime_ff  <= uptime_ff;
         out_frac_ff    <= frac_ff;
         out_seconds_ff <= seconds_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_compare = out_next_ff;
   assign rsp_uptime_ms    = out_uptime_ff;
   assign rsp_fraction_ms  = out_frac_ff;
   assign rsp_unix_seconds = out_seconds_ff;

endmodule

// ----- sv/tktcs_div.sv -----
// Restoring divider, one quotient bit per cycle, registered results.
// Depends on tktcs_pkg for its default widths.
module tktcs_div import tktcs_pkg::*; #(
   parameter int DividendWidth = DividendW,
   parameter int DivisorWidth  = TickW
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DividendWidth-1:0] dividend,
   input  logic [DivisorWidth-1:0]  divisor,
   output logic                     done,
   output logic [DividendWidth-1:0] quotient,
   output logic [DivisorWidth-1:0]  remainder
);

   localparam int CountW = $clog2(DividendWidth);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CountW-1:0]        count_ff, count_in;
   logic [DividendWidth-1:0] quo_ff, quo_in;
   logic [DivisorWidth-1:0]  rem_ff, rem_in;
   logic [DivisorWidth-1:0]  divisor_ff, divisor_in;
   logic [DivisorWidth:0]    trial;
   logic [DivisorWidth+1:0]  diff;
   logic                     last;

   assign trial = {rem_ff, quo_ff[DividendWidth-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign last  = (count_ff == CountW'(DividendWidth - 1));

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (diff[DivisorWidth+1]) begin
            rem_in = trial[DivisorWidth-1:0];
            quo_in = {quo_ff[DividendWidth-2:0], 1'b0};
         end else begin
            rem_in = diff[DivisorWidth-1:0];
            quo_in = {quo_ff[DividendWidth-2:0], 1'b1};
         end
         count_in = count_ff + CountW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- tb/tick_timekeeper_compare_scheduler_top_tb.sv -----
// Self-checking testbench for the tick timekeeper with compare scheduler.
// Depends on tktcs_pkg and tick_timekeeper_compare_scheduler_top; a directed table
// is followed by random phases with varied register settings and handshake idling.
module tick_timekeeper_compare_scheduler_top_tb;
   import tktcs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumRows       = 24;
   localparam int NumPhases     = 8;
   localparam int ItemsPerPhase = 205;
   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 100;

   typedef struct packed {
      logic [CounterW-1:0] next_compare;
      logic [UptimeW-1:0]  uptime_ms;
      logic [MsW-1:0]      fraction_ms;
      logic [SecondsW-1:0] unix_seconds;
   } timekeeping_type;

   typedef struct packed {
      bit                  is_csr;
      csr_index_type       idx;
      logic [TickW-1:0]    data;
      logic [CounterW-1:0] sample;
      bit                  typed;
      timekeeping_type     want;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CounterW-1:0]  req_counter_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CounterW-1:0]  rsp_next_compare;
   logic [UptimeW-1:0]   rsp_uptime_ms;
   logic [MsW-1:0]       rsp_fraction_ms;
   logic [SecondsW-1:0]  rsp_unix_seconds;
   logic                 csr_write_enable = 1'b0;
   csr_index_type        csr_index = CSR_TICKS_PER_PERIOD;
   logic [TickW-1:0]     csr_write_data = '0;

   // Own copy of the registers and the time-keeping state.
   logic [TickW-1:0]     cfg_ticks = TicksReset;
   logic [MsW-1:0]       cfg_ms = MsReset;
   logic [TickW-1:0]     cfg_guard = GuardReset;
   logic [CounterW-1:0]  acc_count = '0;
   logic [UptimeW-1:0]   uptime_acc = '0;
   logic [MsW-1:0]       fraction_acc = '0;
   logic [SecondsW-1:0]  seconds_acc = '0;

   timekeeping_type      expected_q[$];
   timekeeping_type      rsp_want;
   int unsigned          req_idle_pct = 0;
   int unsigned          rsp_stall_pct = 0;
   int unsigned          mismatches = 0;
   int unsigned          beats_sent = 0;
   int unsigned          results_checked = 0;
   int unsigned          csr_writes = 0;
   int unsigned          negative_diffs = 0;
   int unsigned          guard_skips = 0;
   int unsigned          idle_cycles = 0;

   directed_row_type plan [0:NumRows-1] = '{
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'd0, 1'b1,
        '{64'd72000, 32'd0, 10'd0, 32'd0}},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'd72000, 1'b1,
        '{64'd144000, 32'd1, 10'd1, 32'd0}},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'd136800, 1'b1,
        '{64'd216000, 32'd1, 10'd1, 32'd0}},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'd71999, 1'b1,
        '{64'd144000, 32'd1, 10'd1, 32'd0}},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h8000_0000_8001_193F, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h7FFF_FFFF_0000_0000, 1'b0, '0},
      '{1'b1, CSR_MS_PER_PERIOD, 31'd1023, 64'd0, 1'b0, '0},
      '{1'b1, CSR_TICKS_PER_PERIOD, 31'd1, 64'd0, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{1'b1, CSR_TICKS_PER_PERIOD, 31'd0, 64'd0, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h5555_5555_5555_5555, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{1'b1, CSR_TICKS_PER_PERIOD, 31'h7FFF_FFFF, 64'd0, 1'b0, '0},
      '{1'b1, CSR_GUARD_TICKS, 31'h7FFF_FFFF, 64'd0, 1'b0, '0},
      '{1'b1, CSR_MS_PER_PERIOD, 31'd0, 64'd0, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h0000_0001_0000_0000, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h0000_0000_7FFF_FFFF, 1'b0, '0},
      '{1'b1, CSR_TICKS_PER_PERIOD, 31'd5, 64'd0, 1'b0, '0},
      '{1'b1, CSR_GUARD_TICKS, 31'd0, 64'd0, 1'b0, '0},
      '{1'b1, CSR_MS_PER_PERIOD, 31'd1000, 64'd0, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'h0000_0000_0000_0064, 1'b0, '0},
      '{1'b0, CSR_TICKS_PER_PERIOD, 31'd0, 64'hFFFF_FFFF_8000_0000, 1'b0, '0}
   };

   tick_timekeeper_compare_scheduler_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_counter_value (req_counter_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_compare  (rsp_next_compare),
      .rsp_uptime_ms     (rsp_uptime_ms),
      .rsp_fraction_ms   (rsp_fraction_ms),
      .rsp_unix_seconds  (rsp_unix_seconds),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic timekeeping_type advance_timekeeping(input logic [CounterW-1:0] sample);
      logic [DiffW-1:0] low_diff;
      longint           remainder;
      longint           periods;
      longint           msp;
      longint           total;
      timekeeping_type  res;
      low_diff = sample[DiffW-1:0] - acc_count[DiffW-1:0];
      remainder = {{32{low_diff[DiffW-1]}}, low_diff};
      msp = (cfg_ms > 10'd1000) ? 1000 : longint'(cfg_ms);
      if (remainder < 0) begin
         negative_diffs++;
      end
      if (remainder >= 0 && cfg_ticks != '0) begin
         periods = remainder / longint'(cfg_ticks);
         remainder = remainder - periods * longint'(cfg_ticks);
         acc_count = acc_count + 64'(periods * longint'(cfg_ticks));
         uptime_acc = uptime_acc + 32'(periods * msp);
         total = longint'(fraction_acc) + periods * msp;
         seconds_acc = seconds_acc + 32'(total / 1000);
         fraction_acc = 10'(total % 1000);
      end
      res.next_compare = sample + 64'(cfg_ticks) - 64'(remainder);
      if (remainder >= longint'(cfg_ticks) - longint'(cfg_guard)) begin
         res.next_compare = res.next_compare + 64'(cfg_ticks);
         guard_skips++;
      end
      res.uptime_ms = uptime_acc;
      res.fraction_ms = fraction_acc;
      res.unix_seconds = seconds_acc;
      return res;
   endfunction

   // Mostly samples a few whole periods on from the accounted count, with the remainder
   // often placed around the guard threshold; the rest are late, boundary or wild samples.
   function automatic logic [CounterW-1:0] pick_sample();
      logic [CounterW-1:0] span;
      logic [CounterW-1:0] sample;
      longint              threshold;
      int unsigned         pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         span = 64'(cfg_ticks) * 64'($urandom_range(0, 3));
         threshold = longint'(cfg_ticks) - longint'(cfg_guard);
         if (cfg_ticks == '0) begin
            span = span + 64'($urandom_range(0, 100000));
         end else if ($urandom_range(0, 1) == 0) begin
            span = span + 64'($urandom_range(0, cfg_ticks - 1));
         end else begin
            span = span + 64'(threshold) + 64'($urandom_range(0, 2)) - 64'd1;
         end
      end else if (pick < 80) begin
         span = 64'd0 - 64'd1 - 64'($urandom_range(0, 32'h7FFF_FFFF));
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0: span = 64'd0;
            1: span = 64'h7FFF_FFFF;
            2: span = 64'h8000_0000;
            default: span = 64'hFFFF_FFFF;
         endcase
      end else begin
         return {$urandom, $urandom};
      end
      sample = acc_count + span;
      if ($urandom_range(0, 3) == 0) begin
         sample[63:32] = $urandom;
      end
      return sample;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
      mismatches++;
   endtask

   task automatic config_write(input csr_index_type idx, input logic [TickW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_TICKS_PER_PERIOD: cfg_ticks = value;
         CSR_MS_PER_PERIOD:    cfg_ms = value[MsW-1:0];
         CSR_GUARD_TICKS:      cfg_guard = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_beat(input logic [CounterW-1:0] value, input bit typed,
                            input timekeeping_type fixed);
      timekeeping_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_counter_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = advance_timekeeping(value);
      expected_q.push_back(typed ? fixed : predicted);
      beats_sent++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_next_compare, '0);
         end else begin
            rsp_want = expected_q.pop_front();
            results_checked++;
            if (rsp_next_compare !== rsp_want.next_compare)
               report_mismatch("next_compare", rsp_next_compare, rsp_want.next_compare);
            if (rsp_uptime_ms !== rsp_want.uptime_ms)
               report_mismatch("uptime_ms", 64'(rsp_uptime_ms), 64'(rsp_want.uptime_ms));
            if (rsp_fraction_ms !== rsp_want.fraction_ms)
               report_mismatch("fraction_ms", 64'(rsp_fraction_ms), 64'(rsp_want.fraction_ms));
            if (rsp_unix_seconds !== rsp_want.unix_seconds)
               report_mismatch("unix_seconds", 64'(rsp_unix_seconds),
                               64'(rsp_want.unix_seconds));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Timed out after %0d cycles without a beat.", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [TickW-1:0] ticks;
      logic [TickW-1:0] guard;
      logic [MsW-1:0]   ms;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain_results();
            config_write(plan[i].idx, plan[i].data);
         end else begin
            send_beat(plan[i].sample, plan[i].typed, plan[i].want);
         end
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         case (phase >> 1)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         case (phase)
            0: begin ticks = 31'd72000; ms = 10'd1; guard = 31'd7200; end
            1: begin
               ticks = 31'($urandom_range(2, 5000));
               ms = 10'($urandom_range(1, 1000));
               guard = 31'($urandom_range(0, ticks - 1));
            end
            2: begin ticks = 31'd1; ms = 10'd1000; guard = 31'd0; end
            3: begin
               ticks = 31'h7FFF_FFFF;
               ms = 10'($urandom_range(1001, 1023));
               guard = 31'h7FFF_FFFF;
            end
            4: begin ticks = 31'($urandom); ms = 10'd0; guard = 31'($urandom); end
            5: begin
               ticks = 31'($urandom_range(100, 100000));
               ms = 10'($urandom_range(1, 1023));
               guard = ticks - 31'($urandom_range(1, 50));
            end
            6: begin
               ticks = 31'd0;
               ms = 10'($urandom_range(0, 1023));
               guard = 31'($urandom_range(0, 1000));
            end
            default: begin
               ticks = 31'($urandom_range(1000, 1000000));
               ms = 10'($urandom_range(500, 1000));
               guard = 31'($urandom_range(ticks, 32'h7FFF_FFFF));
            end
         endcase
         drain_results();
         config_write(CSR_TICKS_PER_PERIOD, ticks);
         config_write(CSR_MS_PER_PERIOD, 31'(ms));
         config_write(CSR_GUARD_TICKS, guard);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_beat(pick_sample(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d beats, checked %0d results, made %0d register writes.",
               beats_sent, results_checked, csr_writes);
      $display("Saw %0d late samples and %0d compares pushed out by the guard.",
               negative_diffs, guard_skips);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/tktcs_pkg.sv
sv/tktcs_div.sv
sv/tick_timekeeper_compare_scheduler_top.sv
tb/tick_timekeeper_compare_scheduler_top_tb.sv
